// ===== src/tcd_pkg.sv =====
// shared types, constants and lookup tables for the typesetter code decoder
package tcd_pkg;

   localparam int POS_BITS = 20;
   localparam int SUM_W    = ((POS_BITS > 18) ? POS_BITS : 18) + 2;
   localparam int CMP_W    = ((POS_BITS + 1) > 20) ? (POS_BITS + 1) : 20;
   localparam int WIDTH_W  = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef logic signed [POS_BITS-1:0] pos_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   localparam sum_type SUM_POS_MAX = sum_type'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
   localparam sum_type SUM_POS_MIN = sum_type'(-(64'sd1 <<< (POS_BITS - 1)));

   localparam logic [CSR_AW-1:0]  ADDR_WIDTH_DOTS  = CSR_AW'(0);
   localparam logic [WIDTH_W-1:0] WIDTH_DOTS_RESET = WIDTH_W'(2112);

   localparam logic [5:0] SIZE_POINTS_RESET = 6'd10;

   // command codes
   localparam logic [7:0] CODE_INIT       = 8'o100;
   localparam logic [7:0] CODE_RAIL_LOWER = 8'o101;
   localparam logic [7:0] CODE_RAIL_UPPER = 8'o102;
   localparam logic [7:0] CODE_MAG_UPPER  = 8'o103;
   localparam logic [7:0] CODE_MAG_LOWER  = 8'o104;
   localparam logic [7:0] CODE_LOWER_CASE = 8'o105;
   localparam logic [7:0] CODE_UPPER_CASE = 8'o106;
   localparam logic [7:0] CODE_ESC_FWD    = 8'o107;
   localparam logic [7:0] CODE_ESC_BACK   = 8'o110;
   localparam logic [7:0] CODE_LEAD_FWD   = 8'o112;
   localparam logic [7:0] CODE_LEAD_BACK  = 8'o114;
   localparam logic [7:0] CODE_PAGE_BREAK = 8'o115;
   localparam logic [7:0] CODE_LONG_LEAD  = 8'o116;

   localparam logic EVENT_GLYPH = 1'b0;
   localparam logic EVENT_PAGE  = 1'b1;

   localparam logic [6:0] UPPER_CASE_BIT = 7'o100;

   typedef struct packed {
      pos_type    escape_accum;
      logic       escape_backward;
      logic       lead_backward;
      logic       upper_case;
      logic [1:0] rail_mag_bits;
      logic [5:0] size_points;
      logic       last_doubled;
      pos_type    row_pos;
      pos_type    col_pos;
      logic       started;
      logic       await_lead;
   } tcd_state_type;

   typedef struct packed {
      logic       event_kind;
      logic [6:0] glyph_code;
      logic [1:0] font_select;
      logic [5:0] point_size;
      pos_type    row_units;
      pos_type    col_units;
   } tcd_result_type;

   function automatic logic [5:0] size_points_lookup(input logic [3:0] k);
      logic [5:0] pts;
      case (k)
         4'd0:    pts = 6'd7;
         4'd1:    pts = 6'd8;
         4'd2:    pts = 6'd10;
         4'd3:    pts = 6'd11;
         4'd4:    pts = 6'd12;
         4'd5:    pts = 6'd14;
         4'd6:    pts = 6'd18;
         4'd7:    pts = 6'd9;
         4'd8:    pts = 6'd6;
         4'd9:    pts = 6'd16;
         4'd10:   pts = 6'd20;
         4'd11:   pts = 6'd22;
         4'd12:   pts = 6'd24;
         4'd13:   pts = 6'd28;
         4'd14:   pts = 6'd36;
         default: pts = 6'd0;
      endcase
      return pts;
   endfunction

   // doubler lens in use for size codes 9 through 14
   function automatic logic size_doubled(input logic [3:0] k);
      return (k >= 4'd9) && (k <= 4'd14);
   endfunction

   function automatic pos_type sat_pos(input sum_type v);
      pos_type r;
      if (v > SUM_POS_MAX) begin
         r = pos_type'(SUM_POS_MAX);
      end else if (v < SUM_POS_MIN) begin
         r = pos_type'(SUM_POS_MIN);
      end else begin
         r = v[POS_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/typesetter_code_decoder_core.sv =====
// top level of the typesetter code decoder: state, result register and csr port
//
// Decodes a phototypesetter command byte stream, one byte per transaction, into
// glyph placement and page break events. While req_ready is high a byte is taken
// every clock cycle: the decode of one byte is a single pass of logic between the
// state registers and the result register, and req_ready stays high while the
// result register is empty or being drained. Bytes that cause no event (escapes,
// leads, size and mode changes) give no response transaction. Rows and columns
// saturate at the signed 20-bit range. width_dots sits at csr address 0 and must
// be written while the decoder is idle.
module typesetter_code_decoder_core import tcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_code_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_event_kind,
   output logic [6:0]          rsp_glyph_code,
   output logic [1:0]          rsp_font_select,
   output logic [5:0]          rsp_point_size,
   output logic signed [POS_BITS-1:0] rsp_row_units,
   output logic signed [POS_BITS-1:0] rsp_col_units,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam tcd_state_type STATE_RESET = '{
      escape_accum:    '0,
      escape_backward: 1'b0,
      lead_backward:   1'b0,
      upper_case:      1'b0,
      rail_mag_bits:   2'b00,
      size_points:     SIZE_POINTS_RESET,
      last_doubled:    1'b0,
      row_pos:         '0,
      col_pos:         '0,
      started:         1'b0,
      await_lead:      1'b0
   };

   tcd_state_type       state_ff;
   tcd_state_type       state_in;
   tcd_result_type      result_ff;
   tcd_result_type      result_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [WIDTH_W-1:0]  width_dots_ff;
   logic [WIDTH_W-1:0]  width_dots_in;
   logic                dec_valid;
   logic                req_accept;
   logic                csr_write;

   tcd_decode u_decode (
      .cur_state  (state_ff),
      .code_byte  (req_code_byte),
      .width_dots (width_dots_ff),
      .nxt_state  (state_in),
      .res_valid  (dec_valid),
      .result     (result_in)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = dec_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_dots_in = width_dots_ff;
      if (csr_write && (csr_paddr == ADDR_WIDTH_DOTS)) begin
         width_dots_in = csr_pwdata[WIDTH_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_WIDTH_DOTS) begin
         csr_prdata = CSR_DW'(width_dots_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         rsp_valid_ff  <= 1'b0;
         width_dots_ff <= WIDTH_DOTS_RESET;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         width_dots_ff <= width_dots_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && dec_valid) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = result_ff.event_kind;
   assign rsp_glyph_code  = result_ff.glyph_code;
   assign rsp_font_select = result_ff.font_select;
   assign rsp_point_size  = result_ff.point_size;
   assign rsp_row_units   = result_ff.row_units;
   assign rsp_col_units   = result_ff.col_units;

endmodule

// ===== src/tcd_decode.sv =====
// next-state and event decode for one command byte
module tcd_decode import tcd_pkg::*; (
   input  tcd_state_type        cur_state,
   input  logic [7:0]           code_byte,
   input  logic [WIDTH_W-1:0]   width_dots,
   output tcd_state_type        nxt_state,
   output logic                 res_valid,
   output tcd_result_type       result
);

   logic [13:0]       lead_steps;
   logic [15:0]       lead_amount;
   sum_type           row_sum;
   sum_type           col_sum;
   sum_type           esc_sum;
   pos_type           col_applied;
   logic [CMP_W-1:0]  row_x4;
   logic [CMP_W-1:0]  width_x9;
   logic              glyph_drop;
   logic              new_doubled;
   pos_type           corr;

   always_comb begin
      if (cur_state.await_lead) begin
         lead_steps = {code_byte, 6'b0};
      end else begin
         lead_steps = {9'b0, ~code_byte[4:0]};
      end
      lead_amount = {2'b0, lead_steps} + {1'b0, lead_steps, 1'b0};
      if (cur_state.lead_backward) begin
         row_sum = sum_type'(cur_state.row_pos) - sum_type'(lead_amount);
      end else begin
         row_sum = sum_type'(cur_state.row_pos) + sum_type'(lead_amount);
      end

      esc_sum = sum_type'(cur_state.escape_accum) + sum_type'({1'b0, ~code_byte[6:0]});

      if (cur_state.escape_backward) begin
         col_sum = sum_type'(cur_state.col_pos) - sum_type'(cur_state.escape_accum);
      end else begin
         col_sum = sum_type'(cur_state.col_pos) + sum_type'(cur_state.escape_accum);
      end
      col_applied = sat_pos(col_sum);

      row_x4     = CMP_W'(cur_state.row_pos[POS_BITS-2:0]) << 2;
      width_x9   = (CMP_W'(width_dots) << 3) + CMP_W'(width_dots);
      glyph_drop = cur_state.row_pos[POS_BITS-1] || (row_x4 >= width_x9);

      new_doubled = size_doubled(code_byte[3:0]);
      if (!cur_state.last_doubled && new_doubled) begin
         corr = pos_type'(-55);
      end else if (cur_state.last_doubled && !new_doubled) begin
         corr = pos_type'(55);
      end else begin
         corr = '0;
      end
      if (cur_state.escape_backward) begin
         corr = -corr;
      end
   end

   always_comb begin
      nxt_state = cur_state;
      res_valid = 1'b0;
      result.event_kind  = EVENT_GLYPH;
      result.glyph_code  = '0;
      result.font_select = cur_state.rail_mag_bits;
      result.point_size  = cur_state.size_points;
      result.row_units   = '0;
      result.col_units   = '0;

      if (cur_state.await_lead) begin
         nxt_state.await_lead = 1'b0;
         nxt_state.row_pos    = sat_pos(row_sum);
      end else if (code_byte == 8'd0) begin
         nxt_state = cur_state;
      end else if (code_byte[7]) begin
         nxt_state.escape_accum = sat_pos(esc_sum);
      end else begin
         // pending escape lands on the column first
         if (cur_state.escape_accum != '0) begin
            nxt_state.col_pos = col_applied;
         end
         nxt_state.escape_accum = '0;

         if (!code_byte[6]) begin
            if (!glyph_drop) begin
               res_valid          = 1'b1;
               result.event_kind  = EVENT_GLYPH;
               result.glyph_code  = {1'b0, code_byte[5:0]}
                                    | (cur_state.upper_case ? UPPER_CASE_BIT : 7'd0);
               result.row_units   = cur_state.row_pos;
               result.col_units   = nxt_state.col_pos;
            end
         end else if (code_byte[5]) begin
            nxt_state.row_pos = sat_pos(row_sum);
         end else if (code_byte[4]) begin
            nxt_state.escape_accum = corr;
            nxt_state.last_doubled = new_doubled;
            nxt_state.size_points  = size_points_lookup(code_byte[3:0]);
         end else begin
            case (code_byte)
               CODE_INIT: begin
                  nxt_state.escape_accum    = '0;
                  nxt_state.lead_backward   = 1'b0;
                  nxt_state.escape_backward = 1'b0;
                  nxt_state.upper_case      = 1'b0;
                  nxt_state.rail_mag_bits   = 2'b00;
                  nxt_state.started         = 1'b1;
                  nxt_state.row_pos         = '0;
                  nxt_state.col_pos         = '0;
                  if (cur_state.started) begin
                     res_valid          = 1'b1;
                     result.event_kind  = EVENT_PAGE;
                     result.font_select = 2'b00;
                  end
               end
               CODE_RAIL_LOWER: nxt_state.rail_mag_bits[0] = 1'b0;
               CODE_RAIL_UPPER: nxt_state.rail_mag_bits[0] = 1'b1;
               CODE_MAG_UPPER:  nxt_state.rail_mag_bits[1] = 1'b1;
               CODE_MAG_LOWER:  nxt_state.rail_mag_bits[1] = 1'b0;
               CODE_LOWER_CASE: nxt_state.upper_case       = 1'b0;
               CODE_UPPER_CASE: nxt_state.upper_case       = 1'b1;
               CODE_ESC_FWD:    nxt_state.escape_backward  = 1'b0;
               CODE_ESC_BACK:   nxt_state.escape_backward  = 1'b1;
               CODE_LEAD_FWD:   nxt_state.lead_backward    = 1'b0;
               CODE_LEAD_BACK:  nxt_state.lead_backward    = 1'b1;
               CODE_PAGE_BREAK: begin
                  nxt_state.row_pos = '0;
                  nxt_state.col_pos = '0;
                  res_valid         = 1'b1;
                  result.event_kind = EVENT_PAGE;
               end
               CODE_LONG_LEAD:  nxt_state.await_lead       = 1'b1;
               default:         nxt_state.await_lead       = 1'b0;
            endcase
         end
      end
   end

endmodule

// ===== src/tcd_checker.sv =====
// port-level assertions for the typesetter code decoder, bound to the top level
module tcd_checker import tcd_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_event_kind,
   input logic [6:0]                  rsp_glyph_code,
   input logic [5:0]                  rsp_point_size,
   input logic signed [POS_BITS-1:0]  rsp_row_units,
   input logic signed [POS_BITS-1:0]  rsp_col_units
);

   // a stalled response transaction stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // page breaks report the origin and no glyph
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EVENT_PAGE) |->
         (rsp_row_units == '0) && (rsp_col_units == '0) && (rsp_glyph_code == '0))
      else $error("page break with nonzero position or glyph");

   // placed glyphs never sit above the raster
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EVENT_GLYPH) |-> !rsp_row_units[POS_BITS-1])
      else $error("glyph emitted at negative row");

   // point size does not exceed the largest table value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_point_size <= 6'd36))
      else $error("point size out of range");

   // an empty result register never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

endmodule

bind typesetter_code_decoder_core tcd_checker u_tcd_checker (.*);
